@@ sv/buddy_block_allocator_macros.svh @@
// Assertion macros used by the buddy block allocator top level.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bba_pkg.sv @@
// Shared types, constants and command codes of the buddy block allocator.
package bba_pkg;

  localparam int unsigned LEN_W      = 26;
  localparam int unsigned NEED_W     = 27;
  localparam int unsigned ORD_W      = 4;
  localparam int unsigned BLOG_W     = 5;
  localparam int unsigned POOL_W     = 4;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned HDR_BYTES  = 13;
  localparam int unsigned BLOG_MIN   = 4;
  localparam int unsigned BLOG_MAX   = 16;
  localparam int unsigned BLOG_RESET = 5;
  localparam int unsigned POOL_RESET = 10;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_FAIL  = 1'b1;

  localparam logic REG_BLOCK_SIZE_LOG2 = 1'b0;
  localparam logic REG_POOL_ORDERS     = 1'b1;

  // Commands from the controller to the datapath, one per cycle
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_LOAD,
    CMD_SIZE_STEP,
    CMD_SRCH_INIT,
    CMD_SRCH_RD,
    CMD_SRCH_NEXT,
    CMD_TAKE,
    CMD_SPLIT,
    CMD_TAG,
    CMD_ORD_RD,
    CMD_ORD_LOAD,
    CMD_UP_RD,
    CMD_UP_NEXT,
    CMD_MG_INIT,
    CMD_MG_RD,
    CMD_MG_TAKE,
    CMD_SET,
    CMD_FAIL
  } cmd_e;

  // Conditions reported by the datapath
  typedef struct packed {
    logic clr_last;
    logic size_fit;
    logic k_over;
    logic fm_free;
    logic srch_last;
    logic o_eq_k;
    logic o_at_top;
    logic addr_bad;
    logic ord_bad;
  } dp_stat_t;

endpackage

@@ sv/bba_ram.sv @@
// Generic single-port RAM with registered read data.
module bba_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bba_dp.sv @@
// Datapath of the buddy block allocator: config, walk registers, free map and order store.
module bba_dp #(
  parameter int unsigned MaxOrder = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic [bba_pkg::LEN_W-1:0]     request_length_i,
  input  logic [bba_pkg::LEN_W-1:0]     free_address_i,
  input  bba_pkg::cmd_e                 cmd_i,
  output bba_pkg::dp_stat_t             stat_o,
  output logic                          done_o,
  output logic                          status_o,
  output logic [bba_pkg::LEN_W-1:0]     payload_offset_o
);

  localparam int unsigned MW     = MaxOrder;
  localparam int unsigned AW     = MaxOrder + 1;
  localparam int unsigned FmDepth = 2 ** AW;
  localparam int unsigned BoDepth = 2 ** MW;
  localparam int unsigned OW     = bba_pkg::ORD_W;
  localparam int unsigned LW     = bba_pkg::LEN_W;
  localparam int unsigned NW     = bba_pkg::NEED_W;

  // Config registers
  logic [bba_pkg::BLOG_W-1:0] blog_q;
  logic [bba_pkg::POOL_W-1:0] pool_q;

  // Walk registers
  logic [NW-1:0] need_q, need_d;
  logic [LW-1:0] addr_q, addr_d;
  logic [OW-1:0] k_q, k_d, o_q, o_d, ord_q, ord_d;
  logic [MW-1:0] p_q, p_d, w_q, w_d, idx_q, idx_d;
  logic [AW-1:0] clr_q;
  logic          done_q, done_d, status_q, status_d;
  logic [LW-1:0] offset_q, offset_d;

  // Memory ports
  logic          fm_we, fm_wdata, fm_rdata;
  logic [AW-1:0] fm_addr;
  logic          bo_we;
  logic [MW-1:0] bo_addr;
  logic [OW-1:0] bo_rdata;

  // Derived values
  logic [OW-1:0] pool_eff;
  logic [5:0]    blog_eff, span, sh_k;
  logic [LW-1:0] off, low_mask;
  logic [MW-1:0] idx, ord_mask;
  logic [MW:0]   cnt_m1;
  logic          p_last;

  // Tree node index: whole pool sits at the top of the array order
  function automatic logic [AW-1:0] node_addr(input logic [OW-1:0] o, input logic [MW-1:0] p);
    logic [4:0]    sh;
    logic [AW-1:0] base;
    sh   = 5'(MaxOrder) - 5'(o);
    base = (AW'(1) << sh) - AW'(1);
    return base + AW'(p);
  endfunction

  // Effective pool order and basic block size
  always_comb begin
    pool_eff = (pool_q > OW'(MaxOrder)) ? OW'(MaxOrder) : pool_q;
    if (blog_q < bba_pkg::BLOG_W'(bba_pkg::BLOG_MIN)) begin
      blog_eff = 6'(bba_pkg::BLOG_MIN);
    end else if (blog_q > bba_pkg::BLOG_W'(bba_pkg::BLOG_MAX)) begin
      blog_eff = 6'(bba_pkg::BLOG_MAX);
    end else begin
      blog_eff = 6'(blog_q);
    end
    if (blog_eff + 6'(pool_eff) > 6'(LW)) begin
      blog_eff = 6'(LW) - 6'(pool_eff);
    end
  end

  // Sizing, search and free checks
  always_comb begin
    sh_k     = blog_eff + 6'(k_q);
    span     = blog_eff + 6'(pool_eff);
    off      = addr_q - LW'(bba_pkg::HDR_BYTES);
    low_mask = (LW'(1) << blog_eff) - LW'(1);
    idx      = MW'(off >> blog_eff);
    cnt_m1   = ((MW+1)'(1) << (pool_eff - o_q)) - (MW+1)'(1);
    p_last   = ({1'b0, p_q} == cnt_m1);
    ord_mask = MW'(((MW+1)'(1) << bo_rdata) - (MW+1)'(1));

    stat_o.clr_last  = &clr_q;
    stat_o.size_fit  = (sh_k >= 6'(NW)) || ((NW'(1) << sh_k) >= need_q);
    stat_o.k_over    = k_q > pool_eff;
    stat_o.fm_free   = fm_rdata;
    stat_o.srch_last = p_last && (o_q == pool_eff);
    stat_o.o_eq_k    = o_q == k_q;
    stat_o.o_at_top  = o_q == pool_eff;
    stat_o.addr_bad  = (addr_q < LW'(bba_pkg::HDR_BYTES))
                    || ((span < 6'(LW)) && (off >= (LW'(1) << span)))
                    || (|(off & low_mask));
    stat_o.ord_bad   = (bo_rdata > pool_eff) || (|(idx_q & ord_mask));
  end

  // Memory address and write selection
  always_comb begin
    fm_we    = 1'b0;
    fm_wdata = 1'b0;
    fm_addr  = node_addr(o_q, p_q);
    bo_we    = 1'b0;
    bo_addr  = idx;
    case (cmd_i)
      bba_pkg::CMD_CLR: begin
        fm_addr  = clr_q;
        fm_we    = 1'b1;
        fm_wdata = (clr_q == node_addr(pool_eff, '0));
      end
      bba_pkg::CMD_TAKE: begin
        fm_we = 1'b1;
      end
      bba_pkg::CMD_SPLIT: begin
        fm_addr  = node_addr(o_q - OW'(1), MW'({p_q, 1'b1}));
        fm_we    = 1'b1;
        fm_wdata = 1'b1;
      end
      bba_pkg::CMD_UP_RD: begin
        fm_addr = node_addr(o_q, w_q);
      end
      bba_pkg::CMD_MG_RD: begin
        fm_addr = node_addr(o_q, p_q ^ MW'(1));
      end
      bba_pkg::CMD_MG_TAKE: begin
        fm_addr = node_addr(o_q, p_q ^ MW'(1));
        fm_we   = 1'b1;
      end
      bba_pkg::CMD_SET: begin
        fm_we    = 1'b1;
        fm_wdata = 1'b1;
      end
      bba_pkg::CMD_TAG: begin
        bo_addr = MW'(p_q << k_q);
        bo_we   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Register updates per command
  always_comb begin
    need_d   = need_q;
    addr_d   = addr_q;
    k_d      = k_q;
    o_d      = o_q;
    p_d      = p_q;
    w_d      = w_q;
    idx_d    = idx_q;
    ord_d    = ord_q;
    done_d   = 1'b0;
    status_d = status_q;
    offset_d = offset_q;
    case (cmd_i)
      bba_pkg::CMD_LOAD: begin
        need_d = NW'(request_length_i) + NW'(bba_pkg::HDR_BYTES);
        addr_d = free_address_i;
        k_d    = '0;
      end
      bba_pkg::CMD_SIZE_STEP: k_d = k_q + OW'(1);
      bba_pkg::CMD_SRCH_INIT: begin
        o_d = k_q;
        p_d = '0;
      end
      bba_pkg::CMD_SRCH_NEXT: begin
        if (p_last) begin
          o_d = o_q + OW'(1);
          p_d = '0;
        end else begin
          p_d = p_q + MW'(1);
        end
      end
      bba_pkg::CMD_SPLIT: begin
        o_d = o_q - OW'(1);
        p_d = p_q << 1;
      end
      bba_pkg::CMD_TAG: begin
        done_d   = 1'b1;
        status_d = bba_pkg::ST_OK;
        offset_d = (LW'(p_q) << sh_k) + LW'(bba_pkg::HDR_BYTES);
      end
      bba_pkg::CMD_ORD_RD: idx_d = idx;
      bba_pkg::CMD_ORD_LOAD: begin
        ord_d = bo_rdata;
        o_d   = bo_rdata;
        p_d   = idx_q >> bo_rdata;
        w_d   = idx_q >> bo_rdata;
      end
      bba_pkg::CMD_UP_NEXT: begin
        o_d = o_q + OW'(1);
        w_d = w_q >> 1;
      end
      bba_pkg::CMD_MG_INIT: o_d = ord_q;
      bba_pkg::CMD_MG_TAKE: begin
        o_d = o_q + OW'(1);
        p_d = p_q >> 1;
      end
      bba_pkg::CMD_SET: begin
        done_d   = 1'b1;
        status_d = bba_pkg::ST_OK;
        offset_d = '0;
      end
      bba_pkg::CMD_FAIL: begin
        done_d   = 1'b1;
        status_d = bba_pkg::ST_FAIL;
        offset_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blog_q <= bba_pkg::BLOG_W'(bba_pkg::BLOG_RESET);
      pool_q <= bba_pkg::POOL_W'(bba_pkg::POOL_RESET);
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (cfg_we_i) begin
        clr_q <= '0;
        if (cfg_index_i == bba_pkg::REG_BLOCK_SIZE_LOG2) begin
          blog_q <= cfg_wdata_i[bba_pkg::BLOG_W-1:0];
        end else begin
          pool_q <= cfg_wdata_i[bba_pkg::POOL_W-1:0];
        end
      end else if (cmd_i == bba_pkg::CMD_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    addr_q   <= addr_d;
    k_q      <= k_d;
    o_q      <= o_d;
    p_q      <= p_d;
    w_q      <= w_d;
    idx_q    <= idx_d;
    ord_q    <= ord_d;
    status_q <= status_d;
    offset_q <= offset_d;
  end

  bba_ram #(.Width(1), .Depth(FmDepth)) u_free_map (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .addr_i  (fm_addr),
    .wdata_i (fm_wdata),
    .rdata_o (fm_rdata)
  );

  bba_ram #(.Width(OW), .Depth(BoDepth)) u_block_order (
    .clk_i   (clk_i),
    .we_i    (bo_we),
    .addr_i  (bo_addr),
    .wdata_i (k_q),
    .rdata_o (bo_rdata)
  );

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign payload_offset_o = offset_q;

endmodule

@@ sv/bba_ctrl.sv @@
// Controller state machine of the buddy block allocator.
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              opcode_i,
  input  logic              cfg_we_i,
  input  bba_pkg::dp_stat_t stat_i,
  output bba_pkg::cmd_e     cmd_o,
  output logic              busy_o
);

  typedef enum logic [11:0] {
    S_CLEAR     = 12'b000000000001,
    S_IDLE      = 12'b000000000010,
    S_A_SIZE    = 12'b000000000100,
    S_A_RD      = 12'b000000001000,
    S_A_CHK     = 12'b000000010000,
    S_A_SPLIT   = 12'b000000100000,
    S_F_CHK     = 12'b000001000000,
    S_F_ORD     = 12'b000010000000,
    S_F_UP_RD   = 12'b000100000000,
    S_F_UP_CHK  = 12'b001000000000,
    S_F_MG_RD   = 12'b010000000000,
    S_F_MG_CHK  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // Next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = bba_pkg::CMD_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o = bba_pkg::CMD_CLR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = bba_pkg::CMD_LOAD;
          state_d = (opcode_i == bba_pkg::OP_ALLOC) ? S_A_SIZE : S_F_CHK;
        end
      end
      S_A_SIZE: begin
        if (stat_i.k_over) begin
          cmd_o   = bba_pkg::CMD_FAIL;
          state_d = S_IDLE;
        end else if (stat_i.size_fit) begin
          cmd_o   = bba_pkg::CMD_SRCH_INIT;
          state_d = S_A_RD;
        end else begin
          cmd_o = bba_pkg::CMD_SIZE_STEP;
        end
      end
      S_A_RD: begin
        cmd_o   = bba_pkg::CMD_SRCH_RD;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        if (stat_i.fm_free) begin
          cmd_o   = bba_pkg::CMD_TAKE;
          state_d = S_A_SPLIT;
        end else if (stat_i.srch_last) begin
          cmd_o   = bba_pkg::CMD_FAIL;
          state_d = S_IDLE;
        end else begin
          cmd_o   = bba_pkg::CMD_SRCH_NEXT;
          state_d = S_A_RD;
        end
      end
      S_A_SPLIT: begin
        if (stat_i.o_eq_k) begin
          cmd_o   = bba_pkg::CMD_TAG;
          state_d = S_IDLE;
        end else begin
          cmd_o = bba_pkg::CMD_SPLIT;
        end
      end
      S_F_CHK: begin
        if (stat_i.addr_bad) begin
          cmd_o   = bba_pkg::CMD_FAIL;
          state_d = S_IDLE;
        end else begin
          cmd_o   = bba_pkg::CMD_ORD_RD;
          state_d = S_F_ORD;
        end
      end
      S_F_ORD: begin
        if (stat_i.ord_bad) begin
          cmd_o   = bba_pkg::CMD_FAIL;
          state_d = S_IDLE;
        end else begin
          cmd_o   = bba_pkg::CMD_ORD_LOAD;
          state_d = S_F_UP_RD;
        end
      end
      S_F_UP_RD: begin
        cmd_o   = bba_pkg::CMD_UP_RD;
        state_d = S_F_UP_CHK;
      end
      S_F_UP_CHK: begin
        if (stat_i.fm_free) begin
          cmd_o   = bba_pkg::CMD_FAIL;
          state_d = S_IDLE;
        end else if (stat_i.o_at_top) begin
          cmd_o   = bba_pkg::CMD_MG_INIT;
          state_d = S_F_MG_RD;
        end else begin
          cmd_o   = bba_pkg::CMD_UP_NEXT;
          state_d = S_F_UP_RD;
        end
      end
      S_F_MG_RD: begin
        if (stat_i.o_at_top) begin
          cmd_o   = bba_pkg::CMD_SET;
          state_d = S_IDLE;
        end else begin
          cmd_o   = bba_pkg::CMD_MG_RD;
          state_d = S_F_MG_CHK;
        end
      end
      S_F_MG_CHK: begin
        if (stat_i.fm_free) begin
          cmd_o   = bba_pkg::CMD_MG_TAKE;
          state_d = S_F_MG_RD;
        end else begin
          cmd_o   = bba_pkg::CMD_SET;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    // A config write reinitializes the pool
    if (cfg_we_i) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ sv/buddy_block_allocator.sv @@
// Top level of the buddy block allocator.
// One item at a time: start is taken while busy is low, and the result appears
// on status/payload_offset with done high for exactly one cycle; the receiver
// cannot stall it. The free map is a single-port RAM with registered read data,
// so each node read takes a read state and a check state, which sets the time.
// After the accepting cycle an allocate raises its order from zero until the
// request fits (k is the needed order), scans the tree nodes (lowest address
// first, from the needed order up, at most 2^(P+1)-1 nodes), splits the free
// block it finds down to order k and records the block. A free checks the
// address and the stored order, checks each level up to the pool order, merges
// with each free buddy, then marks the block free. A rejected item stops at the
// check that fails. done is high in the cycle after the last step. The slowest
// item at the default setting is a smallest-size allocate whose only free block
// is the last node scanned. After reset and after every config write the free
// map is cleared over its 2^(MaxOrder+1) entries (2048 at default) with busy high.
`include "buddy_block_allocator_macros.svh"

module buddy_block_allocator #(
  parameter int unsigned MaxOrder = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      opcode_i,
  input  logic [bba_pkg::LEN_W-1:0] request_length_i,
  input  logic [bba_pkg::LEN_W-1:0] free_address_i,
  output logic                      done_o,
  output logic                      status_o,
  output logic [bba_pkg::LEN_W-1:0] payload_offset_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata_i
);

  bba_pkg::cmd_e     cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .cfg_we_i (cfg_we_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  bba_dp #(.MaxOrder(MaxOrder)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .request_length_i (request_length_i),
    .free_address_i   (free_address_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o)
  );

  // Checks
  `BBA_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "item taken but busy not raised")
  `BBA_ASSERT_NOW(a_fail_zero, done_o && (status_o == bba_pkg::ST_FAIL), payload_offset_o == '0, "failed item has nonzero offset")
  `BBA_ASSERT_NOW(a_done_after_work, done_o, $past(busy_o) && !busy_o, "result without preceding work")

endmodule
